FILE: hw/rtl/resonant_two_pole_filter_assert.svh
// ----------------------------------------------------------------------------
// Resonant two-pole filter assertion macros
// Concurrent check macros used by the filter top level; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef RESONANT_TWO_POLE_FILTER_ASSERT_SVH
`define RESONANT_TWO_POLE_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define RTPF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtpf: same-cycle check failed");
`define RTPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtpf: next-cycle check failed");
`else
`define RTPF_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define RTPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/rtpf_pkg.sv
// ----------------------------------------------------------------------------
// Resonant two-pole filter package
// Widths, register and mode codes, and the structs shared between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpf_pkg;

  localparam int unsigned VOICE_W    = 4;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned STATE_W    = 24;
  localparam int unsigned CUTOFF_W   = 16;
  localparam int unsigned FEEDBACK_W = 23;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 23;
  localparam int unsigned MUL_A_W    = 32;
  localparam int unsigned MUL_B_W    = 24;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;

  localparam logic [MODE_W-1:0] MODE_LOWPASS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HIGHPASS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BANDPASS = 2'd2;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 16'h8000;

  typedef struct packed {
    logic                      rd_en;
    logic                      wr_en;
    logic [VOICE_W:0]          addr;
    logic signed [STATE_W-1:0] s0;
    logic signed [STATE_W-1:0] s1;
  } mem_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [VOICE_W-1:0]         voice;
    logic                       last;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rtpf_state_mem.sv
// ----------------------------------------------------------------------------
// Filter state memory
// Both integrator states per voice and channel, one port, registered read,
// per-entry valid bits so unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpf_state_mem #(
  parameter int unsigned VOICES = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire rtpf_pkg::mem_req_t                req_i,
  output logic signed [rtpf_pkg::STATE_W-1:0]    s0_o,
  output logic signed [rtpf_pkg::STATE_W-1:0]    s1_o
);

  localparam int unsigned VMAX   = 2 ** rtpf_pkg::VOICE_W;
  localparam int unsigned VREACH = (VOICES < VMAX) ? VOICES : VMAX;
  localparam int unsigned DEPTH  = 2 * VREACH;
  localparam int unsigned AW     = $clog2(DEPTH);

  logic [rtpf_pkg::STATE_W-1:0] mem_s0 [DEPTH];
  logic [rtpf_pkg::STATE_W-1:0] mem_s1 [DEPTH];
  logic [DEPTH-1:0]             valid_q;
  logic                         rd_valid_q;
  logic [rtpf_pkg::STATE_W-1:0] rd_s0_q;
  logic [rtpf_pkg::STATE_W-1:0] rd_s1_q;
  logic [AW-1:0]                addr;

  assign addr = req_i.addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_s0[addr] <= req_i.s0;
      mem_s1[addr] <= req_i.s1;
    end
    if (req_i.rd_en) begin
      rd_s0_q <= mem_s0[addr];
      rd_s1_q <= mem_s1[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[addr];
      end
    end
  end

  assign s0_o = rd_valid_q ? rd_s0_q : '0;
  assign s1_o = rd_valid_q ? rd_s1_q : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/rtpf_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 32 x 24 multiply with a registered product, reused for all three multiply passes.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpf_mul (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [rtpf_pkg::MUL_A_W-1:0] a_i,
  input  wire logic signed [rtpf_pkg::MUL_B_W-1:0] b_i,
  output logic signed [rtpf_pkg::PROD_W-1:0]       p_o
);

  logic signed [rtpf_pkg::PROD_W-1:0] p_d;
  logic signed [rtpf_pkg::PROD_W-1:0] p_q;

  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rtpf_ctrl.sv
// ----------------------------------------------------------------------------
// Filter sequencer and datapath
// Steps each channel through read, three multiply/accumulate passes on the
// shared multiplier, state write-back and output selection.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpf_ctrl #(
  parameter int unsigned VOICES = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic [rtpf_pkg::VOICE_W-1:0]           voice_i,
  input  wire logic signed [rtpf_pkg::SAMPLE_W-1:0]   left_in_i,
  input  wire logic signed [rtpf_pkg::SAMPLE_W-1:0]   right_in_i,
  input  wire logic                                   block_last_i,
  input  wire logic [rtpf_pkg::CUTOFF_W-1:0]          cutoff_i,
  input  wire logic [rtpf_pkg::FEEDBACK_W-1:0]        feedback_i,
  input  wire logic [rtpf_pkg::MODE_W-1:0]            mode_i,
  output rtpf_pkg::mem_req_t                          mem_req_o,
  input  wire logic signed [rtpf_pkg::STATE_W-1:0]    mem_s0_i,
  input  wire logic signed [rtpf_pkg::STATE_W-1:0]    mem_s1_i,
  output logic                                        mul_en_o,
  output logic signed [rtpf_pkg::MUL_A_W-1:0]         mul_a_o,
  output logic signed [rtpf_pkg::MUL_B_W-1:0]         mul_b_o,
  input  wire logic signed [rtpf_pkg::PROD_W-1:0]     mul_p_i,
  output logic                                        res_valid_o,
  input  wire logic                                   res_ready_i,
  output rtpf_pkg::result_t                           res_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_LOAD = 4'd2;
  localparam logic [3:0] ST_MUL1 = 4'd3;
  localparam logic [3:0] ST_ACC1 = 4'd4;
  localparam logic [3:0] ST_MUL2 = 4'd5;
  localparam logic [3:0] ST_ACC2 = 4'd6;
  localparam logic [3:0] ST_DIF  = 4'd7;
  localparam logic [3:0] ST_MUL3 = 4'd8;
  localparam logic [3:0] ST_ACC3 = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  localparam int unsigned SW = rtpf_pkg::STATE_W;
  localparam int unsigned XW = rtpf_pkg::SAMPLE_W;
  localparam int unsigned AW = rtpf_pkg::MUL_A_W;
  localparam int unsigned BW = rtpf_pkg::MUL_B_W;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic fits;
    fits = (&v[40:31]) || !(|v[40:31]);
    if (fits) return v[31:0];
    else if (v[40]) return {1'b1, {31{1'b0}}};
    else return {1'b0, {31{1'b1}}};
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [40:0] v);
    logic fits;
    fits = (&v[40:23]) || !(|v[40:23]);
    if (fits) return v[23:0];
    else if (v[40]) return {1'b1, {23{1'b0}}};
    else return {1'b0, {23{1'b1}}};
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [40:0] v);
    logic fits;
    fits = (&v[40:15]) || !(|v[40:15]);
    if (fits) return v[15:0];
    else if (v[40]) return {1'b1, {15{1'b0}}};
    else return {1'b0, {15{1'b1}}};
  endfunction

  logic [3:0]                     state_q, state_d;
  logic                           ch_q, ch_d;
  logic [rtpf_pkg::VOICE_W-1:0]   voice_q, voice_d;
  logic                           last_q, last_d;
  logic signed [XW-1:0]           xl_q, xl_d, xr_q, xr_d;
  logic signed [SW-1:0]           s0_q, s0_d, s1_q, s1_d;
  logic signed [AW-1:0]           a_q, a_d;
  logic signed [BW-1:0]           b_q, b_d;
  logic signed [XW-1:0]           lo_q, lo_d, ro_q, ro_d;

  logic                           voice_ok;
  logic signed [XW+4:0]           x_cur;
  logic signed [39:0]             prod_sh;
  logic signed [40:0]             acc1, acc2, acc3;
  logic signed [SW:0]             dif, rd_dif;
  logic signed [40:0]             out_pre, out_sh;
  logic signed [XW-1:0]           out_smp;
  logic signed [SW-1:0]           s1_new;

  assign voice_ok = 32'(voice_i) < VOICES;
  assign x_cur    = {(ch_q ? xr_q : xl_q), 5'b0};
  assign prod_sh  = mul_p_i[rtpf_pkg::PROD_W-1:16];
  assign acc1     = 41'(x_cur) - 41'(s0_q) + 41'(prod_sh);
  assign acc2     = 41'(s0_q) + 41'(prod_sh);
  assign acc3     = 41'(s1_q) + 41'(prod_sh);
  assign dif      = 25'(s0_q) - 25'(s1_q);
  assign rd_dif   = 25'(mem_s0_i) - 25'(mem_s1_i);
  assign s1_new   = sat24(acc3);

  always_comb begin
    unique case (mode_i)
      rtpf_pkg::MODE_LOWPASS:  out_pre = 41'(s1_q);
      rtpf_pkg::MODE_HIGHPASS: out_pre = 41'(x_cur) - 41'(s0_q);
      rtpf_pkg::MODE_BANDPASS: out_pre = 41'(dif);
      default:                 out_pre = '0;
    endcase
  end

  assign out_sh  = out_pre >>> 5;
  assign out_smp = sat16(out_sh);

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    voice_d = voice_q;
    last_d  = last_q;
    xl_d    = xl_q;
    xr_d    = xr_q;
    s0_d    = s0_q;
    s1_d    = s1_q;
    a_d     = a_q;
    b_d     = b_q;
    lo_d    = lo_q;
    ro_d    = ro_q;

    mem_req_o       = '0;
    mem_req_o.addr  = {voice_q, ch_q};
    mem_req_o.s0    = s0_q;
    mem_req_o.s1    = s1_new;
    mul_en_o        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          voice_d = voice_i;
          last_d  = block_last_i;
          xl_d    = left_in_i;
          xr_d    = right_in_i;
          ch_d    = 1'b0;
          lo_d    = '0;
          ro_d    = '0;
          state_d = voice_ok ? ST_RD : ST_DONE;
        end
      end
      ST_RD: begin
        mem_req_o.rd_en = 1'b1;
        state_d         = ST_LOAD;
      end
      ST_LOAD: begin
        s0_d    = mem_s0_i;
        s1_d    = mem_s1_i;
        a_d     = 32'(rd_dif);
        b_d     = {1'b0, feedback_i};
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        mul_en_o = 1'b1;
        state_d  = ST_ACC1;
      end
      ST_ACC1: begin
        a_d     = sat32(acc1);
        b_d     = {8'b0, cutoff_i};
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        mul_en_o = 1'b1;
        state_d  = ST_ACC2;
      end
      ST_ACC2: begin
        s0_d    = sat24(acc2);
        state_d = ST_DIF;
      end
      ST_DIF: begin
        a_d     = 32'(dif);
        state_d = ST_MUL3;
      end
      ST_MUL3: begin
        mul_en_o = 1'b1;
        state_d  = ST_ACC3;
      end
      ST_ACC3: begin
        s1_d            = s1_new;
        mem_req_o.wr_en = 1'b1;
        state_d         = ST_OUT;
      end
      ST_OUT: begin
        if (ch_q) begin
          ro_d    = out_smp;
          state_d = ST_DONE;
        end else begin
          lo_d    = out_smp;
          ch_d    = 1'b1;
          state_d = ST_RD;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    voice_q <= voice_d;
    last_q  <= last_d;
    xl_q    <= xl_d;
    xr_q    <= xr_d;
    s0_q    <= s0_d;
    s1_q    <= s1_d;
    a_q     <= a_d;
    b_q     <= b_d;
    lo_q    <= lo_d;
    ro_q    <= ro_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign mul_a_o     = a_q;
  assign mul_b_o     = b_q;
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o.left  = lo_q;
  assign res_o.right = ro_q;
  assign res_o.voice = voice_q;
  assign res_o.last  = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/resonant_two_pole_filter.sv
// ----------------------------------------------------------------------------
// Resonant two-pole filter
// Multi-voice stereo state-variable style filter with lowpass, highpass and
// bandpass outputs, configuration registers and a registered result stage.
// ----------------------------------------------------------------------------
// One request is taken at a time. For a voice in range each channel in turn
// goes through state read, three multiply and accumulate passes through the
// single shared 32x24 multiplier, state write-back and output pick, between
// accept and hand-off; a voice out of range goes straight from accept to
// hand-off. The result register lets the next request in while the previous
// result is still stalled. Filter states read as zero after reset through
// per-entry valid bits, so no clearing pass is needed. Write configuration
// only while the filter is idle.
`default_nettype none

module resonant_two_pole_filter #(
  parameter int unsigned VOICES = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [rtpf_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [rtpf_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic [rtpf_pkg::VOICE_W-1:0]           voice_i,
  input  wire logic signed [rtpf_pkg::SAMPLE_W-1:0]   left_in_i,
  input  wire logic signed [rtpf_pkg::SAMPLE_W-1:0]   right_in_i,
  input  wire logic                                   block_last_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [rtpf_pkg::SAMPLE_W-1:0]        left_out_o,
  output logic signed [rtpf_pkg::SAMPLE_W-1:0]        right_out_o,
  output logic [rtpf_pkg::VOICE_W-1:0]                voice_out_o,
  output logic                                        block_last_out_o
);

  `include "resonant_two_pole_filter_assert.svh"

  logic [rtpf_pkg::CUTOFF_W-1:0]              cutoff_q;
  logic [rtpf_pkg::FEEDBACK_W-1:0]            feedback_q;
  logic [rtpf_pkg::MODE_W-1:0]                mode_q;

  rtpf_pkg::mem_req_t                         mem_req;
  logic signed [rtpf_pkg::STATE_W-1:0]        mem_s0, mem_s1;
  logic                                       mul_en;
  logic signed [rtpf_pkg::MUL_A_W-1:0]        mul_a;
  logic signed [rtpf_pkg::MUL_B_W-1:0]        mul_b;
  logic signed [rtpf_pkg::PROD_W-1:0]         mul_p;
  logic                                       res_valid, res_ready;
  rtpf_pkg::result_t                          res;

  logic                                       out_valid_q;
  rtpf_pkg::result_t                          out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q   <= rtpf_pkg::CUTOFF_RESET;
      feedback_q <= '0;
      mode_q     <= rtpf_pkg::MODE_LOWPASS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rtpf_pkg::CFG_CUTOFF:   cutoff_q   <= cfg_wdata_i[rtpf_pkg::CUTOFF_W-1:0];
        rtpf_pkg::CFG_FEEDBACK: feedback_q <= cfg_wdata_i[rtpf_pkg::FEEDBACK_W-1:0];
        rtpf_pkg::CFG_MODE:     mode_q     <= cfg_wdata_i[rtpf_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  rtpf_ctrl #(
    .VOICES (VOICES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .voice_i      (voice_i),
    .left_in_i    (left_in_i),
    .right_in_i   (right_in_i),
    .block_last_i (block_last_i),
    .cutoff_i     (cutoff_q),
    .feedback_i   (feedback_q),
    .mode_i       (mode_q),
    .mem_req_o    (mem_req),
    .mem_s0_i     (mem_s0),
    .mem_s1_i     (mem_s1),
    .mul_en_o     (mul_en),
    .mul_a_o      (mul_a),
    .mul_b_o      (mul_b),
    .mul_p_i      (mul_p),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  rtpf_state_mem #(
    .VOICES (VOICES)
  ) u_state_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .s0_o   (mem_s0),
    .s1_o   (mem_s1)
  );

  rtpf_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_out_o       = out_q.left;
  assign right_out_o      = out_q.right;
  assign voice_out_o      = out_q.voice;
  assign block_last_out_o = out_q.last;

  `RTPF_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `RTPF_ASSERT_NEXT(a_result_loads, clk_i, rst_ni, res_valid && res_ready, out_valid_o)
  `RTPF_ASSERT_SAME(a_idle_no_result, clk_i, rst_ni, !in_stall_o, !res_valid)

endmodule

`default_nettype wire

FILE: bench/filter_output_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filter output checker
// Watches the configuration port and both request channels of the resonant
// two-pole filter, keeps its own copy of the per-voice integrator states,
// computes each expected result in fixed point and compares it field by field
// with what leaves the filter. Hands the pending and failure counts upward.
// ----------------------------------------------------------------------------

module filter_output_checker #(
  parameter int unsigned VOICES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rtpf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rtpf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [rtpf_pkg::VOICE_W-1:0]         voice_i,
  input  logic signed [rtpf_pkg::SAMPLE_W-1:0] left_in_i,
  input  logic signed [rtpf_pkg::SAMPLE_W-1:0] right_in_i,
  input  logic                                 block_last_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [rtpf_pkg::SAMPLE_W-1:0] left_out_i,
  input  logic signed [rtpf_pkg::SAMPLE_W-1:0] right_out_i,
  input  logic [rtpf_pkg::VOICE_W-1:0]         voice_out_i,
  input  logic                                 block_last_out_i,
  output int                                   pending_o,
  output int                                   fail_count_o
);

  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned FIFO_DEPTH  = 16;
  localparam int unsigned VOICE_W     = rtpf_pkg::VOICE_W;
  localparam int unsigned SAMPLE_W    = rtpf_pkg::SAMPLE_W;
  localparam int unsigned STATE_W     = rtpf_pkg::STATE_W;
  localparam int unsigned CUTOFF_W    = rtpf_pkg::CUTOFF_W;
  localparam int unsigned FEEDBACK_W  = rtpf_pkg::FEEDBACK_W;
  localparam int unsigned MODE_W      = rtpf_pkg::MODE_W;

  logic [CUTOFF_W-1:0]       cutoff_q;
  logic [FEEDBACK_W-1:0]     feedback_q;
  logic [MODE_W-1:0]         mode_q;
  logic signed [STATE_W-1:0] first_stage_q  [2*VOICES];
  logic signed [STATE_W-1:0] second_stage_q [2*VOICES];
  rtpf_pkg::result_t         expected_fifo [FIFO_DEPTH];
  int                        exp_wr_ptr;
  int                        exp_rd_ptr;
  int                        pending_cnt;
  int                        fail_cnt;

  assign pending_o    = pending_cnt;
  assign fail_count_o = fail_cnt;

  function automatic longint saturate(longint v, int unsigned bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] to_q15(longint q420);
    longint s;
    s = saturate(q420 >>> 5, SAMPLE_W);
    return s[SAMPLE_W-1:0];
  endfunction

  // advance both integrators of one voice and channel, pick the mode's tap
  function automatic logic signed [SAMPLE_W-1:0] filter_channel(int unsigned slot,
                                                                longint x);
    longint c;
    longint fb;
    longint s0;
    longint s1;
    longint d;
    c  = longint'(cutoff_q);
    fb = longint'(feedback_q);
    s0 = longint'(first_stage_q[slot]);
    s1 = longint'(second_stage_q[slot]);
    d  = saturate(x - s0 + (((s0 - s1) * fb) >>> 16), 32);
    s0 = saturate(s0 + ((d * c) >>> 16), STATE_W);
    s1 = saturate(s1 + (((s0 - s1) * c) >>> 16), STATE_W);
    first_stage_q[slot]  = s0[STATE_W-1:0];
    second_stage_q[slot] = s1[STATE_W-1:0];
    case (mode_q)
      rtpf_pkg::MODE_LOWPASS:  return to_q15(s1);
      rtpf_pkg::MODE_HIGHPASS: return to_q15(x - s0);
      rtpf_pkg::MODE_BANDPASS: return to_q15(s0 - s1);
      default:                 return '0;
    endcase
  endfunction

  function automatic rtpf_pkg::result_t filtered_sample(logic [VOICE_W-1:0] v,
                                                        logic signed [SAMPLE_W-1:0] l,
                                                        logic signed [SAMPLE_W-1:0] r,
                                                        logic last);
    rtpf_pkg::result_t res;
    res.left  = '0;
    res.right = '0;
    res.voice = v;
    res.last  = last;
    if (v < VOICES) begin
      res.left  = filter_channel(32'({v, 1'b0}), longint'(l) * 32);
      res.right = filter_channel(32'({v, 1'b1}), longint'(r) * 32);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rtpf_pkg::result_t got;
    rtpf_pkg::result_t want;
    if (!rst_ni) begin
      cutoff_q    = rtpf_pkg::CUTOFF_RESET;
      feedback_q  = '0;
      mode_q      = rtpf_pkg::MODE_LOWPASS;
      pending_cnt = 0;
      fail_cnt    = 0;
      exp_wr_ptr  = 0;
      exp_rd_ptr  = 0;
      for (int i = 0; i < 2 * VOICES; i++) begin
        first_stage_q[i]  = '0;
        second_stage_q[i] = '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rtpf_pkg::CFG_CUTOFF:   cutoff_q   = cfg_wdata_i[CUTOFF_W-1:0];
          rtpf_pkg::CFG_FEEDBACK: feedback_q = cfg_wdata_i[FEEDBACK_W-1:0];
          rtpf_pkg::CFG_MODE:     mode_q     = cfg_wdata_i[MODE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (pending_cnt == FIFO_DEPTH) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: too many requests in flight", $realtime);
        end else begin
          expected_fifo[exp_wr_ptr] = filtered_sample(voice_i, left_in_i, right_in_i,
                                                      block_last_i);
          exp_wr_ptr  = (exp_wr_ptr + 1) % FIFO_DEPTH;
          pending_cnt = pending_cnt + 1;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        got.left  = left_out_i;
        got.right = right_out_i;
        got.voice = voice_out_i;
        got.last  = block_last_out_i;
        if (pending_cnt == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result L=%0d R=%0d voice=%0d last=%0b",
                     $realtime, got.left, got.right, got.voice, got.last);
        end else begin
          want        = expected_fifo[exp_rd_ptr];
          exp_rd_ptr  = (exp_rd_ptr + 1) % FIFO_DEPTH;
          pending_cnt = pending_cnt - 1;
          if (got.left !== want.left || got.right !== want.right ||
              got.voice !== want.voice || got.last !== want.last) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS) begin
              $display("%0t: mismatch expected L=%0d R=%0d voice=%0d last=%0b",
                       $realtime, want.left, want.right, want.voice, want.last);
              $display("%0t:          got      L=%0d R=%0d voice=%0d last=%0b",
                       $realtime, got.left, got.right, got.voice, got.last);
            end
          end
        end
      end
    end
  end

endmodule

FILE: bench/tb_resonant_two_pole_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resonant two-pole filter testbench
// Drives short directed sample sets at the field extremes in every mode, then
// random phases of reconfigured filters fed with ramps, extremes and noise on
// a small set of busy voices. Requests come in bursts with random gaps and
// the output side stalls on its own pattern; a separate checker predicts and
// compares every result.
// ----------------------------------------------------------------------------

module tb_resonant_two_pole_filter;

  localparam int unsigned VOICES         = 16;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned PHASE_SAMPLES  = 125;
  localparam int unsigned SETTLE_CYCLES  = 30;
  localparam int unsigned CYCLE_LIMIT    = 600000;

  localparam int unsigned VOICE_W    = rtpf_pkg::VOICE_W;
  localparam int unsigned SAMPLE_W   = rtpf_pkg::SAMPLE_W;
  localparam int unsigned CUTOFF_W   = rtpf_pkg::CUTOFF_W;
  localparam int unsigned FEEDBACK_W = rtpf_pkg::FEEDBACK_W;
  localparam int unsigned MODE_W     = rtpf_pkg::MODE_W;
  localparam int unsigned CFG_IDX_W  = rtpf_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = rtpf_pkg::CFG_DATA_W;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;

  logic                        clk          = 1'b0;
  logic                        rst_n        = 1'b0;
  logic                        cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx      = rtpf_pkg::CFG_CUTOFF;
  logic [CFG_DATA_W-1:0]       cfg_wdata    = '0;
  logic                        in_valid     = 1'b0;
  logic [VOICE_W-1:0]          voice        = '0;
  logic signed [SAMPLE_W-1:0]  left_in      = '0;
  logic signed [SAMPLE_W-1:0]  right_in     = '0;
  logic                        block_last   = 1'b0;
  logic                        out_stall    = 1'b0;
  logic                        in_stall;
  logic                        out_valid;
  logic signed [SAMPLE_W-1:0]  left_out;
  logic signed [SAMPLE_W-1:0]  right_out;
  logic [VOICE_W-1:0]          voice_out;
  logic                        block_last_out;
  int                          pending;
  int                          fail_count;

  int                          burst_left = 0;
  int                          gap_max    = 0;
  int                          cycle_count;
  logic [SAMPLE_W-1:0]         ramp_q [VOICES];

  resonant_two_pole_filter #(
    .VOICES(VOICES)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .voice_i         (voice),
    .left_in_i       (left_in),
    .right_in_i      (right_in),
    .block_last_i    (block_last),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .left_out_o      (left_out),
    .right_out_o     (right_out),
    .voice_out_o     (voice_out),
    .block_last_out_o(block_last_out)
  );

  filter_output_checker #(
    .VOICES(VOICES)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .voice_i         (voice),
    .left_in_i       (left_in),
    .right_in_i      (right_in),
    .block_last_i    (block_last),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .left_out_i      (left_out),
    .right_out_i     (right_out),
    .voice_out_i     (voice_out),
    .block_last_out_i(block_last_out),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // output side: free runs, coin-flip stalls and periodic stall windows
  initial begin
    int kind;
    int seg_len;
    int stall_on;
    int period;
    forever begin
      kind     = $urandom_range(0, 2);
      seg_len  = $urandom_range(20, 300);
      stall_on = $urandom_range(1, 24);
      period   = stall_on + $urandom_range(1, 24);
      for (int k = 0; k < seg_len; k++) begin
        @(posedge clk);
        case (kind)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ((k % period) < stall_on);
        endcase
      end
    end
  end

  task automatic send_sample(logic [VOICE_W-1:0] v, logic signed [SAMPLE_W-1:0] l,
                             logic signed [SAMPLE_W-1:0] r, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    voice      <= v;
    left_in    <= l;
    right_in   <= r;
    block_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid and hold until every result has come back
  task automatic drain;
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_filter(logic [CUTOFF_W-1:0] cutoff, logic [FEEDBACK_W-1:0] fb,
                            logic [MODE_W-1:0] mode);
    cfg_we    <= 1'b1;
    cfg_idx   <= rtpf_pkg::CFG_CUTOFF;
    cfg_wdata <= {7'($urandom), cutoff};
    @(posedge clk);
    cfg_idx   <= rtpf_pkg::CFG_FEEDBACK;
    cfg_wdata <= fb;
    @(posedge clk);
    cfg_idx   <= rtpf_pkg::CFG_MODE;
    cfg_wdata <= {21'($urandom), mode};
    @(posedge clk);
    cfg_idx   <= CFG_UNUSED;
    cfg_wdata <= 23'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(logic [VOICE_W-1:0] v);
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return SAMPLE_W'($urandom);
    if (r < 55) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh8000;
        1:       return 16'sh7fff;
        2:       return 16'sh0000;
        default: return 16'shffff;
      endcase
    end
    return ramp_q[v];
  endfunction

  initial begin
    int unsigned cutoff;
    int unsigned fb;
    int          buf_len;
    int          buf_pos;
    logic [VOICE_W-1:0] v;
    logic [VOICE_W-1:0] voice_base;
    logic [MODE_W-1:0]  mode;

    for (int i = 0; i < VOICES; i++) ramp_q[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: lowpass at half cutoff, no feedback
    send_sample(4'd0, 16'sh7fff, 16'sh8000, 1'b0);
    send_sample(4'd0, 16'sh7fff, 16'sh8000, 1'b1);
    send_sample(4'd15, 16'sh8000, 16'sh7fff, 1'b0);
    send_sample(4'd15, 16'sh0000, 16'shffff, 1'b1);
    drain();

    set_filter(16'd64880, 23'h7fffff, rtpf_pkg::MODE_HIGHPASS);
    send_sample(4'd1, 16'sh7fff, 16'sh8000, 1'b0);
    send_sample(4'd1, 16'sh7fff, 16'sh8000, 1'b0);
    send_sample(4'd15, 16'sh8000, 16'sh7fff, 1'b1);
    send_sample(4'd0, 16'sh0000, 16'sh0000, 1'b0);
    drain();

    set_filter(16'hffff, 23'd65536, rtpf_pkg::MODE_BANDPASS);
    send_sample(4'd2, 16'sh7fff, 16'sh7fff, 1'b0);
    send_sample(4'd2, 16'sh8000, 16'sh8000, 1'b0);
    send_sample(4'd2, 16'sh7fff, 16'sh8000, 1'b1);
    send_sample(4'd10, 16'sh5555, 16'shaaaa, 1'b0);
    send_sample(4'd5, 16'shaaaa, 16'sh5555, 1'b1);
    drain();

    set_filter(16'd0, 23'd0, MODE_UNUSED);
    send_sample(4'd3, 16'sh7fff, 16'sh8000, 1'b0);
    send_sample(4'd15, 16'sh8000, 16'sh7fff, 1'b1);
    send_sample(4'd1, 16'sh1234, 16'shedcb, 1'b0);
    drain();

    set_filter(16'd1, 23'h7fffff, rtpf_pkg::MODE_LOWPASS);
    send_sample(4'd4, 16'sh7fff, 16'sh8000, 1'b0);
    send_sample(4'd4, 16'sh7fff, 16'sh8000, 1'b0);
    send_sample(4'd4, 16'sh8000, 16'sh7fff, 1'b1);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       cutoff = 0;
        1:       cutoff = 64880;
        2:       cutoff = 65535;
        3:       cutoff = $urandom_range(500, 8000);
        4:       cutoff = $urandom_range(8000, 64880);
        default: cutoff = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 4))
        0:       fb = 0;
        1:       fb = 23'h7fffff;
        2:       fb = $urandom_range(0, 1 << 18);
        3:       fb = $urandom_range(0, 1 << 17);
        default: fb = $urandom_range(0, 23'h7fffff);
      endcase
      mode = MODE_W'(p % 4);
      gap_max = (p % 3 == 0) ? 0 : $urandom_range(1, 16);
      set_filter(CUTOFF_W'(cutoff), FEEDBACK_W'(fb), mode);

      voice_base = VOICE_W'($urandom);
      buf_len    = $urandom_range(4, 32);
      buf_pos    = 0;
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        if ($urandom_range(0, 9) < 7) v = voice_base + VOICE_W'($urandom_range(0, 3));
        else v = VOICE_W'($urandom);
        ramp_q[v] = ramp_q[v] + SAMPLE_W'(1 << $urandom_range(6, 12));
        buf_pos++;
        send_sample(v, pick_sample(v), pick_sample(v),
                    (buf_pos == buf_len) || ($urandom_range(0, 19) == 0));
        if (buf_pos == buf_len) buf_pos = 0;
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
